// ===== hw/rtl/unused_vertex_compactor_core_assert.svh =====
// Assertion macros for the unused vertex compactor.
// Included by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef UNUSED_VERTEX_COMPACTOR_CORE_ASSERT_SVH
`define UNUSED_VERTEX_COMPACTOR_CORE_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define UVC_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define UVC_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/uvc_pkg.sv =====
// Shared constants for the unused vertex compactor: field widths, codes, default sizes.
// No dependencies.
package uvc_pkg;

  localparam int unsigned IDX_W = 12;   // vertex number as carried by a load
  localparam int unsigned POS_W = 14;   // position field of a result
  localparam int unsigned NUM_W = 12;   // new number field of a result
  localparam int unsigned CFG_W = 13;   // vertex count register

  localparam int unsigned DEF_MAX_VERTICES = 4096;
  localparam int unsigned DEF_MAX_INDICES  = 16384;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

endpackage

// ===== hw/rtl/unused_vertex_compactor_core.sv =====
// Unused vertex compactor: loads triangle indices, then emits vertex renumber records
// followed by remapped indices. Depends on uvc_pkg and unused_vertex_compactor_core_assert.svh.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready) writes the vertex count; always ready. Write it only
//   while the block is idle; a running emission keeps the count it took at its start.
//   in channel (in_valid/in_stall) carries one beat per item: mode 0 loads an index,
//   mode 1 pulls the next result. out channel (out_valid/out_stall) carries results.
// Sequencing:
//   A load is taken while idle and keeps the block idle, so loads can stream back to back.
//   A pull of a vertex record goes through issue, vertex memory read and commit; a pull
//   of an index record goes through index memory read, then a dependent vertex memory read.
//   The pull steps follow from the registered reads of the two memories, and the block
//   works on one pull at a time.
// Reset and stall:
//   After reset the vertex mark memory is swept clear with in_stall high. After the last
//   beat of a run, marks at or above the run's vertex count are swept in the same way;
//   marks below it are cleared as the vertex records go out.
//   A result sits in the output register while out_stall is high; the next pull finishes
//   its reads and then waits for that register to free up.
module unused_vertex_compactor_core
  import uvc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_INDICES  = DEF_MAX_INDICES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_vertex_count,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_mode,
  input  logic [IDX_W-1:0] in_index_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [POS_W-1:0] out_position,
  output logic             out_kept,
  output logic [NUM_W-1:0] out_new_number,
  output logic             out_last,
  output logic             out_bad_index_seen
);

  `include "unused_vertex_compactor_core_assert.svh"

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned IW  = $clog2(MAX_INDICES);
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned LW  = $clog2(MAX_INDICES + 1);
  localparam int unsigned PW  = (VCW > LW) ? VCW : LW;
  localparam int unsigned EW  = NUM_W + 1;   // mark bit over rename value

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_ISSUE, S_IDX, S_VOUT, S_IOUT} state_t;
  typedef enum logic [1:0] {PH_LOAD, PH_VERT, PH_IDX} phase_t;

  // vertex memory: {used mark, rename value}; index memory: stored vertex numbers
  logic [EW-1:0]    vmem [MAX_VERTICES];
  logic [IDX_W-1:0] imem [MAX_INDICES];
  logic [EW-1:0]    vmem_q;
  logic [IDX_W-1:0] imem_q;

  logic             vmem_we, vmem_re, imem_we, imem_re;
  logic [VW-1:0]    vmem_wa, vmem_ra;
  logic [EW-1:0]    vmem_wd;
  logic [IW-1:0]    imem_wa, imem_ra;
  logic [IDX_W-1:0] imem_wd;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CFG_W-1:0] vcount_r, vcount_nxt;
  logic [VCW-1:0]   run_v_r, run_v_nxt;
  logic [LW-1:0]    loaded_r, loaded_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [VCW-1:0]   kc_r, kc_nxt;
  logic             err_r, err_nxt;
  logic             mark_any_r, mark_any_nxt;
  logic [VW-1:0]    max_mark_r, max_mark_nxt;
  logic [VW-1:0]    clr_ptr_r, clr_ptr_nxt;
  logic [VW-1:0]    clr_end_r, clr_end_nxt;
  logic             idx_ok_r, idx_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_kept_r, out_kept_nxt;
  logic [NUM_W-1:0] out_num_r, out_num_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_bad_r, out_bad_nxt;
  logic             out_load;

  logic             in_acc, slot_free, in_range, store_full, last_beat, kept;
  logic [VCW-1:0]   vc_eff;
  logic [VW-1:0]    load_va;
  logic [PW-1:0]    ptr_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign vc_eff     = (32'(vcount_r) > MAX_VERTICES) ? VCW'(MAX_VERTICES) : VCW'(vcount_r);
  assign in_range   = 32'(in_index_value) < 32'(vc_eff);
  assign store_full = 32'(loaded_r) >= MAX_INDICES;
  assign load_va    = VW'(in_index_value);
  assign ptr_inc    = ptr_r + PW'(1);
  assign kept       = vmem_q[EW-1];

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    vcount_nxt   = cfg_valid ? cfg_vertex_count : vcount_r;
    run_v_nxt    = run_v_r;
    loaded_nxt   = loaded_r;
    ptr_nxt      = ptr_r;
    kc_nxt       = kc_r;
    err_nxt      = err_r;
    mark_any_nxt = mark_any_r;
    max_mark_nxt = max_mark_r;
    clr_ptr_nxt  = clr_ptr_r;
    clr_end_nxt  = clr_end_r;
    idx_ok_nxt   = idx_ok_r;

    out_load     = 1'b0;
    out_kind_nxt = out_kind_r;
    out_pos_nxt  = out_pos_r;
    out_kept_nxt = out_kept_r;
    out_num_nxt  = out_num_r;
    out_last_nxt = out_last_r;
    out_bad_nxt  = out_bad_r;
    last_beat    = 1'b0;

    vmem_we = 1'b0;
    vmem_wa = clr_ptr_r;
    vmem_wd = '0;
    vmem_re = 1'b0;
    vmem_ra = VW'(ptr_r);
    imem_we = 1'b0;
    imem_wa = IW'(loaded_r);
    imem_wd = in_index_value;
    imem_re = 1'b0;
    imem_ra = IW'(ptr_r);

    unique case (state_r)
      S_CLR: begin
        vmem_we = 1'b1;
        if (clr_ptr_r == clr_end_r) begin
          state_nxt = S_IDLE;
        end else begin
          clr_ptr_nxt = clr_ptr_r + VW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc && in_mode == MODE_LOAD) begin
          if (phase_r != PH_LOAD || !in_range || store_full) begin
            err_nxt = 1'b1;
          end else begin
            imem_we      = 1'b1;
            vmem_we      = 1'b1;
            vmem_wa      = load_va;
            vmem_wd      = {1'b1, {NUM_W{1'b0}}};
            loaded_nxt   = loaded_r + LW'(1);
            mark_any_nxt = 1'b1;
            if (!mark_any_r || load_va > max_mark_r) begin
              max_mark_nxt = load_va;
            end
          end
        end else if (in_acc) begin
          if (phase_r == PH_LOAD) begin
            if (vc_eff != '0 || loaded_r != '0) begin
              run_v_nxt = vc_eff;
              ptr_nxt   = '0;
              kc_nxt    = '0;
              phase_nxt = (vc_eff != '0) ? PH_VERT : PH_IDX;
              state_nxt = S_ISSUE;
            end
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        if (phase_r == PH_VERT) begin
          vmem_re   = 1'b1;
          state_nxt = S_VOUT;
        end else begin
          imem_re   = 1'b1;
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        idx_ok_nxt = 32'(imem_q) < 32'(run_v_r);
        vmem_re    = idx_ok_nxt;
        vmem_ra    = VW'(imem_q);
        state_nxt  = S_IOUT;
      end
      S_VOUT: begin
        if (slot_free) begin
          // clear the mark as the record goes out; rename is only meaningful if kept
          vmem_we      = 1'b1;
          vmem_wa      = VW'(ptr_r);
          vmem_wd      = {1'b0, NUM_W'(kc_r)};
          out_load     = 1'b1;
          out_kind_nxt = KIND_VERTEX;
          out_pos_nxt  = POS_W'(ptr_r);
          out_kept_nxt = kept;
          out_num_nxt  = kept ? NUM_W'(kc_r) : '0;
          out_bad_nxt  = err_r;
          kc_nxt       = kc_r + VCW'(kept);
          ptr_nxt      = ptr_inc;
          state_nxt    = S_IDLE;
          if (32'(ptr_inc) >= 32'(run_v_r)) begin
            if (loaded_r == '0) begin
              last_beat = 1'b1;
            end else begin
              phase_nxt = PH_IDX;
              ptr_nxt   = '0;
            end
          end
          out_last_nxt = last_beat;
        end
      end
      S_IOUT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_INDEX;
          out_pos_nxt  = POS_W'(ptr_r);
          out_kept_nxt = 1'b1;
          out_num_nxt  = idx_ok_r ? vmem_q[NUM_W-1:0] : '0;
          out_bad_nxt  = err_r || !idx_ok_r;
          err_nxt      = out_bad_nxt;
          ptr_nxt      = ptr_inc;
          state_nxt    = S_IDLE;
          last_beat    = 32'(ptr_inc) >= 32'(loaded_r);
          out_last_nxt = last_beat;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (last_beat) begin
      phase_nxt    = PH_LOAD;
      loaded_nxt   = '0;
      ptr_nxt      = '0;
      kc_nxt       = '0;
      err_nxt      = 1'b0;
      run_v_nxt    = '0;
      mark_any_nxt = 1'b0;
      // marks beyond the run's vertex range were not visited; sweep them
      if (mark_any_r && 32'(max_mark_r) >= 32'(run_v_r)) begin
        clr_ptr_nxt = VW'(run_v_r);
        clr_end_nxt = max_mark_r;
        state_nxt   = S_CLR;
      end
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= PH_LOAD;
      vcount_r    <= '0;
      run_v_r     <= '0;
      loaded_r    <= '0;
      ptr_r       <= '0;
      kc_r        <= '0;
      err_r       <= 1'b0;
      mark_any_r  <= 1'b0;
      max_mark_r  <= '0;
      clr_ptr_r   <= '0;
      clr_end_r   <= VW'(MAX_VERTICES - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      vcount_r    <= vcount_nxt;
      run_v_r     <= run_v_nxt;
      loaded_r    <= loaded_nxt;
      ptr_r       <= ptr_nxt;
      kc_r        <= kc_nxt;
      err_r       <= err_nxt;
      mark_any_r  <= mark_any_nxt;
      max_mark_r  <= max_mark_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      clr_end_r   <= clr_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_ok_r   <= idx_ok_nxt;
    out_kind_r <= out_kind_nxt;
    out_pos_r  <= out_pos_nxt;
    out_kept_r <= out_kept_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_wa] <= vmem_wd;
    end
    if (vmem_re) begin
      vmem_q <= vmem[vmem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (imem_we) begin
      imem[imem_wa] <= imem_wd;
    end
    if (imem_re) begin
      imem_q <= imem[imem_ra];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_position       = out_pos_r;
  assign out_kept           = out_kept_r;
  assign out_new_number     = out_num_r;
  assign out_last           = out_last_r;
  assign out_bad_index_seen = out_bad_r;

  `UVC_CHECK(a_loaded_bound, 32'(loaded_r) <= MAX_INDICES, "index store count overran")
  `UVC_CHECK(a_vert_ptr, (phase_r != PH_VERT) || (32'(ptr_r) < 32'(run_v_r)),
             "vertex pointer beyond run vertex count")
  `UVC_CHECK(a_kept_bound, (phase_r != PH_VERT) || (32'(kc_r) <= 32'(ptr_r)),
             "kept counter ahead of vertex pointer")
  `UVC_CHECK_NEXT(a_run_end, out_load && out_last_nxt,
                  phase_r == PH_LOAD && loaded_r == '0 && !err_r,
                  "run state not cleared after last beat")
  `UVC_CHECK(a_clr_range, (state_r != S_CLR) || (clr_ptr_r <= clr_end_r),
             "clearing sweep past its end")

endmodule

// ===== test/unused_vertex_compactor_core_tb.sv =====
// Self-checking testbench for unused_vertex_compactor_core: a directed table, then random
// meshes, all checked beat by beat.
// Depends on uvc_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module unused_vertex_compactor_core_tb;
  import uvc_pkg::*;

  localparam int unsigned VERT_MAX      = DEF_MAX_VERTICES;
  localparam int unsigned IDX_MAX       = DEF_MAX_INDICES;
  localparam int unsigned VA_W          = $clog2(VERT_MAX);
  localparam int unsigned IA_W          = $clog2(IDX_MAX);
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 22;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef enum logic [1:0] {EMIT_LOADING, EMIT_VERTS, EMIT_INDICES} emit_state_t;
  typedef enum logic {ROW_CFG, ROW_BEAT} row_op_t;

  typedef struct {
    logic             kind;
    logic [POS_W-1:0] position;
    logic             kept;
    logic [NUM_W-1:0] new_number;
    logic             last;
    logic             bad;
  } remap_rec_t;

  typedef struct {
    row_op_t          op;
    logic             mode;
    logic [CFG_W-1:0] value;
    bit               typed;
    remap_rec_t       rec;
  } dir_row_t;

  localparam remap_rec_t NO_REC = '{1'b0, '0, 1'b0, '0, 1'b0, 1'b0};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_vertex_count = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_mode = MODE_LOAD;
  logic [IDX_W-1:0] in_index_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_kind;
  logic [POS_W-1:0] out_position;
  logic             out_kept;
  logic [NUM_W-1:0] out_new_number;
  logic             out_last;
  logic             out_bad_index_seen;

  // renumbering predictor state
  logic [CFG_W-1:0] model_count = '0;
  bit               vert_used [VERT_MAX];
  logic [NUM_W-1:0] rename_mem [VERT_MAX];
  logic [IDX_W-1:0] index_mem [IDX_MAX];
  int unsigned      stored_cnt, emit_ptr, kept_cnt, run_verts;
  emit_state_t      emit_state;
  bit               err_flag, run_ended;

  remap_rec_t       expected_recs [$];
  dir_row_t         dir_rows [$];
  int unsigned      errors = 0;
  int unsigned      beats_sent = 0;
  int unsigned      cycle_count = 0;
  bit               calm = 1'b0;

  unused_vertex_compactor_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_vertex_count   (cfg_vertex_count),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_index_value     (in_index_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_position       (out_position),
    .out_kept           (out_kept),
    .out_new_number     (out_new_number),
    .out_last           (out_last),
    .out_bad_index_seen (out_bad_index_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("unused_vertex_compactor_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic int unsigned eff_vertices();
    return (32'(model_count) > VERT_MAX) ? VERT_MAX : 32'(model_count);
  endfunction

  function automatic void clear_mesh();
    foreach (vert_used[i]) vert_used[i] = 1'b0;
    stored_cnt = 0;
    emit_state = EMIT_LOADING;
    emit_ptr   = 0;
    kept_cnt   = 0;
    err_flag   = 1'b0;
    run_verts  = 0;
  endfunction

  function automatic void add_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Returns 1 when the beat yields a result, which is then in rec.
  function automatic bit predict_remap(input logic mode, input logic [IDX_W-1:0] v,
                                       output remap_rec_t rec);
    int unsigned      vc;
    logic [IDX_W-1:0] idx;
    vc  = eff_vertices();
    rec = NO_REC;
    if (mode == MODE_LOAD) begin
      if (emit_state != EMIT_LOADING || v >= vc || stored_cnt >= IDX_MAX) begin
        err_flag = 1'b1;
      end else begin
        index_mem[IA_W'(stored_cnt)] = v;
        vert_used[v] = 1'b1;
        stored_cnt++;
      end
      return 1'b0;
    end
    if (emit_state == EMIT_LOADING) begin
      if (vc == 0 && stored_cnt == 0) return 1'b0;
      run_verts  = vc;
      emit_ptr   = 0;
      kept_cnt   = 0;
      emit_state = (vc != 0) ? EMIT_VERTS : EMIT_INDICES;
    end
    rec.position = POS_W'(emit_ptr);
    if (emit_state == EMIT_VERTS) begin
      rec.kind = KIND_VERTEX;
      rec.kept = vert_used[VA_W'(emit_ptr)];
      if (rec.kept) begin
        rename_mem[VA_W'(emit_ptr)] = NUM_W'(kept_cnt);
        rec.new_number = NUM_W'(kept_cnt);
        kept_cnt++;
      end
      emit_ptr++;
      if (emit_ptr >= run_verts) begin
        if (stored_cnt == 0) begin
          rec.last = 1'b1;
        end else begin
          emit_state = EMIT_INDICES;
          emit_ptr   = 0;
        end
      end
    end else begin
      rec.kind = KIND_INDEX;
      rec.kept = 1'b1;
      idx = index_mem[IA_W'(emit_ptr)];
      // an index left beyond a lowered vertex count maps to 0 and flags
      if (idx < run_verts) rec.new_number = rename_mem[idx];
      else err_flag = 1'b1;
      emit_ptr++;
      rec.last = (emit_ptr >= stored_cnt);
    end
    rec.bad = err_flag;
    if (rec.last) begin
      clear_mesh();
      run_ended = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    remap_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual position %0d",
                 $time, out_position);
        errors++;
      end else begin
        want = expected_recs.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("position", 32'(want.position), 32'(out_position));
        check_field("kept", 32'(want.kept), 32'(out_kept));
        check_field("new_number", 32'(want.new_number), 32'(out_new_number));
        check_field("last", 32'(want.last), 32'(out_last));
        check_field("bad_index_seen", 32'(want.bad), 32'(out_bad_index_seen));
      end
    end
  end

  // Drain results and let the block finish any sweep before touching the register.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] val);
    settle_idle();
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    model_count  = val;
  endtask

  task automatic put_beat(input logic mode, input logic [IDX_W-1:0] v, input bit typed,
                          input remap_rec_t typed_rec);
    remap_rec_t rec;
    bit         has;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_index_value <= v;
    do @(posedge clk); while (in_stall);
    has = predict_remap(mode, v, rec);
    if (typed) expected_recs = {expected_recs, typed_rec};
    else if (has) expected_recs = {expected_recs, rec};
    if (mode == MODE_LOAD || has) beats_sent++;
  endtask

  // One mesh: set the count, load indices, maybe retune the count, then pull to the end.
  task automatic mesh_phase(input int unsigned verts, input int unsigned n_loads,
                            input int unsigned noise_pct);
    int unsigned      vc;
    bit               retuned;
    logic [IDX_W-1:0] v;
    write_count(CFG_W'(verts));
    vc = eff_vertices();
    for (int unsigned i = 0; i < n_loads; i++) begin
      if (vc == 0 || (vc < VERT_MAX && $urandom_range(99) < noise_pct))
        v = IDX_W'($urandom_range(VERT_MAX - 1, vc));
      else
        v = IDX_W'($urandom_range(vc - 1));
      put_beat(MODE_LOAD, v, 1'b0, NO_REC);
    end
    if ($urandom_range(99) < 15) write_count(CFG_W'($urandom_range(20)));
    if (eff_vertices() == 0 && stored_cnt == 0) begin
      // nothing to emit: the pull is ignored
      put_beat(MODE_PULL, IDX_W'($urandom), 1'b0, NO_REC);
      return;
    end
    run_ended = 1'b0;
    retuned   = 1'b0;
    while (!run_ended) begin
      if (emit_state != EMIT_LOADING && $urandom_range(99) < noise_pct / 2) begin
        put_beat(MODE_LOAD, IDX_W'($urandom), 1'b0, NO_REC);
      end else if (emit_state != EMIT_LOADING && !retuned && $urandom_range(99) < 3) begin
        // count written mid-run only matters for the next mesh
        write_count(CFG_W'($urandom_range(VERT_MAX)));
        retuned = 1'b1;
      end else begin
        put_beat(MODE_PULL, IDX_W'($urandom), 1'b0, NO_REC);
      end
    end
  endtask

  initial begin : main_flow
    int unsigned base;
    int unsigned pick;
    int unsigned verts;
    clear_mesh();

    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd0, 1'b0, NO_REC});
    add_row('{ROW_CFG, MODE_LOAD, 13'd4096, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd4095, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd0, 1'b0, NO_REC});
    // count lowered after loading: 4095 falls outside the run
    add_row('{ROW_CFG, MODE_LOAD, 13'd2, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd0, 1'b1, 12'd0, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd1, 1'b0, 12'd0, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd1, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_INDEX, 14'd0, 1'b1, 12'd0, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_INDEX, 14'd1, 1'b1, 12'd0, 1'b1, 1'b1}});
    // run with no vertices: only index records, all flagged
    add_row('{ROW_CFG, MODE_LOAD, 13'd3, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd2, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd2, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd1, 1'b0, NO_REC});
    add_row('{ROW_CFG, MODE_LOAD, 13'd0, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_INDEX, 14'd0, 1'b1, 12'd0, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_INDEX, 14'd1, 1'b1, 12'd0, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_INDEX, 14'd2, 1'b1, 12'd0, 1'b1, 1'b1}});
    // vertex-only run, count rewritten in the middle
    add_row('{ROW_CFG, MODE_LOAD, 13'd4, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd0, 1'b0, 12'd0, 1'b0, 1'b0}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd1, 1'b0, 12'd0, 1'b0, 1'b0}});
    add_row('{ROW_CFG, MODE_LOAD, 13'd1, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd2, 1'b0, 12'd0, 1'b0, 1'b0}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd3, 1'b0, 12'd0, 1'b1, 1'b0}});
    add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b1,
              '{KIND_VERTEX, 14'd0, 1'b0, 12'd0, 1'b1, 1'b0}});
    // small renumbering run
    add_row('{ROW_CFG, MODE_LOAD, 13'd3, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd2, 1'b0, NO_REC});
    add_row('{ROW_BEAT, MODE_LOAD, 13'd0, 1'b0, NO_REC});
    repeat (5) add_row('{ROW_BEAT, MODE_PULL, 13'd0, 1'b0, NO_REC});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG)
        write_count(dir_rows[i].value);
      else
        put_beat(dir_rows[i].mode, dir_rows[i].value[IDX_W-1:0], dir_rows[i].typed,
                 dir_rows[i].rec);
    end

    base = beats_sent;
    while (beats_sent - base < RANDOM_ITEMS) begin
      calm = (beats_sent - base >= 400) && (beats_sent - base < 600);
      pick = $urandom_range(99);
      if (pick < 8) verts = 0;
      else if (pick < 70) verts = $urandom_range(12, 1);
      else if (pick < 95) verts = $urandom_range(64, 13);
      else verts = $urandom_range(300, 65);
      mesh_phase(verts, $urandom_range(24), 10);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_recs.size() == 0)
      $display("unused_vertex_compactor_core verification clean");
    else
      $display("unused_vertex_compactor_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/uvc_pkg.sv
hw/rtl/unused_vertex_compactor_core.sv
test/unused_vertex_compactor_core_tb.sv
